FILE: rtl/core/hull_vertex_ccw_ordering_unit_assert.svh
// Assertion macros used by the hull ordering checker.
`ifndef HULL_VERTEX_CCW_ORDERING_UNIT_ASSERT_SVH
`define HULL_VERTEX_CCW_ORDERING_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define HV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define HV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/hv_pkg.sv
// ----------------------------------------------------------------------------
// hv_pkg
// Control codes for the hull vertex ordering unit.
// ----------------------------------------------------------------------------
package hv_pkg;

    typedef logic [2:0] hv_state_t;
    typedef logic [1:0] hv_phase_t;

    // Sequencer states
    localparam hv_state_t ST_IDLE = 3'd0;
    localparam hv_state_t ST_EXT  = 3'd1;
    localparam hv_state_t ST_CLS  = 3'd2;
    localparam hv_state_t ST_SEL  = 3'd3;
    localparam hv_state_t ST_EMIT = 3'd4;

    // Output phases
    localparam hv_phase_t PH_R   = 2'd0;
    localparam hv_phase_t PH_UP  = 2'd1;
    localparam hv_phase_t PH_L   = 2'd2;
    localparam hv_phase_t PH_LOW = 2'd3;

endpackage

FILE: rtl/core/hv_point_if.sv
// ----------------------------------------------------------------------------
// hv_point_if / hv_vertex_if
// Valid/ready channels for input points and ordered output vertices.
// ----------------------------------------------------------------------------
interface hv_point_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         set_end;

    modport source (output valid, output point_x, output point_y, output set_end,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input set_end,
                    output ready);
endinterface

interface hv_vertex_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic                         out_end;
    logic                         overflowed;

    modport source (output valid, output out_x, output out_y, output out_end,
                    output overflowed, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_end,
                    input overflowed, output ready);
endinterface

FILE: rtl/core/hv_ram.sv
// ----------------------------------------------------------------------------
// hv_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module hv_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/hull_vertex_ccw_ordering_unit.sv
// ----------------------------------------------------------------------------
// hull_vertex_ccw_ordering_unit
// Collects convex hull vertices and emits them in counterclockwise order.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one point per item; set_end marks the last point of a set.
//   Points are taken one per cycle while the unit is idle and written to the
//   point RAM. Points beyond MAX_POINTS are dropped and the set is flagged.
//   After set_end the unit stops taking items and works through the RAM:
//   one pass finds the right and left points, a further pass classifies
//   every point by a cross product and writes the half bit back, and each
//   further vertex costs one selection pass over the RAM read port.
//   out_ch holds each vertex until taken; a stall on out_ch simply pauses
//   the sequencer. out_end marks the last vertex; overflowed is set on all
//   vertices of a set that dropped points.
//   Reset (rst_n low) empties the store and returns the unit to idle; the
//   RAM needs no clearing since only written entries are read.
// ----------------------------------------------------------------------------
module hull_vertex_ccw_ordering_unit
    import hv_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    hv_point_if.sink    in_ch,
    hv_vertex_if.source out_ch
);

    localparam int CB = COORD_BITS;
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DW = 2 * CB + 1;
    localparam int PW = 2 * CB + 2;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

    typedef logic signed [CB-1:0] coord_t;
    typedef logic signed [CB:0]   diff_t;
    typedef logic signed [PW-1:0] prod_t;

    // Ordering: true when point a goes before point b in the given half
    function automatic logic before_f(coord_t ax, coord_t ay, logic [AW-1:0] ai,
                                      coord_t bx, coord_t by, logic [AW-1:0] bi,
                                      logic up);
        logic res;
        if (ax != bx)
        begin
            res = up ? (ax > bx) : (ax < bx);
        end
        else if (ay != by)
        begin
            res = up ? (ay < by) : (ay > by);
        end
        else
        begin
            res = ai < bi;
        end
        return res;
    endfunction

    hv_state_t     state_reg, state_next;
    hv_phase_t     phase_reg, phase_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] emitted_reg, emitted_next;
    logic          drop_reg, drop_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic          issuing_reg, issuing_next;

    logic          s1_vld_reg, s1_last_reg;
    logic [AW-1:0] s1_idx_reg;
    logic          s2_vld_reg, s2_vld_next, s2_last_reg;
    logic [AW-1:0] s2_idx_reg;
    coord_t        s2_x_reg, s2_y_reg;
    diff_t         s2_px_reg, s2_py_reg;
    logic          s3_vld_reg, s3_vld_next, s3_last_reg;
    logic [AW-1:0] s3_idx_reg;
    coord_t        s3_x_reg, s3_y_reg;
    prod_t         s3_p1_reg, s3_p2_reg;

    coord_t        rx_reg, rx_next, ry_reg, ry_next;
    coord_t        lx_reg, lx_next, ly_reg, ly_next;
    logic [AW-1:0] ri_reg, ri_next, li_reg, li_next;
    coord_t        bx_reg, bx_next, by_reg, by_next;
    logic [AW-1:0] bi_reg, bi_next;
    logic          found_reg, found_next;
    coord_t        kx_reg, kx_next, ky_reg, ky_next;
    logic [AW-1:0] ki_reg, ki_next;
    logic          have_last_reg, have_last_next;

    logic          out_valid_reg, out_valid_next;
    coord_t        ox_reg, ox_next, oy_reg, oy_next;
    logic          oend_reg, oend_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic          rd_en;
    logic [DW-1:0] rd_data;

    coord_t        qx, qy;
    logic          qc;
    diff_t         ex, ey;
    logic          in_acc, out_acc, up;

    hv_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign qx      = rd_data[CB-1:0];
    assign qy      = rd_data[2*CB-1:CB];
    assign qc      = rd_data[2*CB];
    assign ex      = diff_t'(lx_reg) - diff_t'(rx_reg);
    assign ey      = diff_t'(ly_reg) - diff_t'(ry_reg);
    assign in_acc  = in_ch.valid && in_ch.ready;
    assign out_acc = out_valid_reg && out_ch.ready;
    assign up      = (phase_reg == PH_UP);
    assign rd_en   = issuing_reg;

    assign in_ch.ready       = (state_reg == ST_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_x      = ox_reg;
    assign out_ch.out_y      = oy_reg;
    assign out_ch.out_end    = oend_reg;
    assign out_ch.overflowed = drop_reg;

    // Write port: loading in idle, half bit write-back in the classify pass
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = {1'b0, in_ch.point_y, in_ch.point_x};
        if (state_reg == ST_IDLE)
        begin
            wr_en = in_acc && (count_reg < MAX_CNT);
        end
        else if (s3_vld_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = s3_idx_reg;
            wr_data = {(s3_p1_reg < s3_p2_reg), s3_y_reg, s3_x_reg};
        end
    end

    // Sequencer
    always_comb
    begin
        logic cand;
        logic right_w, left_w;
        state_next     = state_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        emitted_next   = emitted_reg;
        drop_next      = drop_reg;
        issue_next     = issue_reg;
        issuing_next   = issuing_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        ri_next        = ri_reg;
        lx_next        = lx_reg;
        ly_next        = ly_reg;
        li_next        = li_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        bi_next        = bi_reg;
        found_next     = found_reg;
        kx_next        = kx_reg;
        ky_next        = ky_reg;
        ki_next        = ki_reg;
        have_last_next = have_last_reg;
        out_valid_next = out_valid_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        oend_next      = oend_reg;
        s2_vld_next    = s1_vld_reg && (state_reg == ST_CLS);
        s3_vld_next    = s2_vld_reg;
        cand           = 1'b0;
        right_w        = 1'b0;
        left_w         = 1'b0;

        // Advance the read address of a running pass
        if (issuing_reg)
        begin
            issue_next = issue_reg + 1'b1;
            if (issue_reg == count_reg - 1'b1)
            begin
                issuing_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (count_reg < MAX_CNT)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (in_ch.set_end)
                    begin
                        state_next   = ST_EXT;
                        issuing_next = 1'b1;
                        issue_next   = '0;
                        emitted_next = '0;
                    end
                end
            end
            ST_EXT:
            begin
                // Track rightmost (lowest on tie) and leftmost (highest on tie)
                if (s1_vld_reg)
                begin
                    right_w = (s1_idx_reg == '0) || (qx > rx_reg) ||
                              ((qx == rx_reg) && (qy < ry_reg));
                    left_w  = (s1_idx_reg == '0) || (qx < lx_reg) ||
                              ((qx == lx_reg) && (qy > ly_reg));
                    if (right_w)
                    begin
                        rx_next = qx;
                        ry_next = qy;
                        ri_next = s1_idx_reg;
                    end
                    if (left_w)
                    begin
                        lx_next = qx;
                        ly_next = qy;
                        li_next = s1_idx_reg;
                    end
                    if (s1_last_reg)
                    begin
                        // All points equal: take L from another entry
                        if ((count_reg > 1) && (li_next == ri_next))
                        begin
                            li_next = (CW'(ri_next) == count_reg - 1'b1) ?
                                      '0 : AW'(count_reg - 1'b1);
                        end
                        state_next   = ST_CLS;
                        issuing_next = 1'b1;
                        issue_next   = '0;
                    end
                end
            end
            ST_CLS:
            begin
                // Last half bit written: show R
                if (s3_vld_reg && s3_last_reg)
                begin
                    state_next     = ST_EMIT;
                    phase_next     = PH_R;
                    out_valid_next = 1'b1;
                    ox_next        = rx_reg;
                    oy_next        = ry_reg;
                    oend_next      = (emitted_reg + 1'b1 == count_reg);
                end
            end
            ST_SEL:
            begin
                // Pick the earliest point after the last one emitted
                if (s1_vld_reg)
                begin
                    cand = (s1_idx_reg != ri_reg) && (s1_idx_reg != li_reg) &&
                           (qc == up) &&
                           (!have_last_reg ||
                            before_f(kx_reg, ky_reg, ki_reg, qx, qy, s1_idx_reg, up)) &&
                           (!found_reg ||
                            before_f(qx, qy, s1_idx_reg, bx_reg, by_reg, bi_reg, up));
                    if (cand)
                    begin
                        found_next = 1'b1;
                        bx_next    = qx;
                        by_next    = qy;
                        bi_next    = s1_idx_reg;
                    end
                    if (s1_last_reg)
                    begin
                        state_next     = ST_EMIT;
                        out_valid_next = 1'b1;
                        oend_next      = (emitted_reg + 1'b1 == count_reg);
                        if (found_next)
                        begin
                            ox_next = bx_next;
                            oy_next = by_next;
                            kx_next = bx_next;
                            ky_next = by_next;
                            ki_next = bi_next;
                        end
                        else
                        begin
                            phase_next = PH_L;
                            ox_next    = lx_reg;
                            oy_next    = ly_reg;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                    emitted_next   = emitted_reg + 1'b1;
                    if (emitted_reg + 1'b1 == count_reg)
                    begin
                        state_next = ST_IDLE;
                        count_next = '0;
                        drop_next  = 1'b0;
                    end
                    else
                    begin
                        state_next   = ST_SEL;
                        issuing_next = 1'b1;
                        issue_next   = '0;
                        found_next   = 1'b0;
                        unique case (phase_reg)
                            PH_R:
                            begin
                                phase_next     = PH_UP;
                                have_last_next = 1'b0;
                            end
                            PH_L:
                            begin
                                phase_next     = PH_LOW;
                                have_last_next = 1'b0;
                            end
                            PH_UP, PH_LOW:
                            begin
                                have_last_next = 1'b1;
                            end
                            default:
                            begin
                                have_last_next = 1'b1;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_R;
            count_reg     <= '0;
            emitted_reg   <= '0;
            drop_reg      <= 1'b0;
            issue_reg     <= '0;
            issuing_reg   <= 1'b0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            have_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            emitted_reg   <= emitted_next;
            drop_reg      <= drop_next;
            issue_reg     <= issue_next;
            issuing_reg   <= issuing_next;
            s1_vld_reg    <= issuing_reg;
            s2_vld_reg    <= s2_vld_next;
            s3_vld_reg    <= s3_vld_next;
            found_reg     <= found_next;
            have_last_reg <= have_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and pipeline data registers
    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= issue_reg[AW-1:0];
        s1_last_reg <= (issue_reg == count_reg - 1'b1);
        s2_idx_reg  <= s1_idx_reg;
        s2_last_reg <= s1_last_reg;
        s2_x_reg    <= qx;
        s2_y_reg    <= qy;
        s2_px_reg   <= diff_t'(qx) - diff_t'(rx_reg);
        s2_py_reg   <= diff_t'(qy) - diff_t'(ry_reg);
        s3_idx_reg  <= s2_idx_reg;
        s3_last_reg <= s2_last_reg;
        s3_x_reg    <= s2_x_reg;
        s3_y_reg    <= s2_y_reg;
        s3_p1_reg   <= prod_t'(ex) * prod_t'(s2_py_reg);
        s3_p2_reg   <= prod_t'(ey) * prod_t'(s2_px_reg);
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        ri_reg      <= ri_next;
        lx_reg      <= lx_next;
        ly_reg      <= ly_next;
        li_reg      <= li_next;
        bx_reg      <= bx_next;
        by_reg      <= by_next;
        bi_reg      <= bi_next;
        kx_reg      <= kx_next;
        ky_reg      <= ky_next;
        ki_reg      <= ki_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        oend_reg    <= oend_next;
    end

endmodule

FILE: rtl/core/hv_checker.sv
// ----------------------------------------------------------------------------
// hv_checker
// Port-level checks for the hull vertex ordering unit.
// ----------------------------------------------------------------------------
`include "hull_vertex_ccw_ordering_unit_assert.svh"

module hv_checker #(
    parameter int COORD_BITS = 16
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  set_end,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [COORD_BITS-1:0] out_x,
    input logic [COORD_BITS-1:0] out_y,
    input logic                  out_end
);

    // Hold a stalled vertex
    `HV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_x) && $stable(out_y) && $stable(out_end),
                    "stalled vertex changed")

    // Never take points while vertices are pending
    `HV_ASSERT_NOW(a_no_overlap, out_valid, !in_ready, "point taken during output")

    // A point without set_end causes no vertex
    `HV_ASSERT_NEXT(a_no_early_out, in_valid && in_ready && !set_end, !out_valid,
                    "vertex without end of set")

    // Closing a set stops intake
    `HV_ASSERT_NEXT(a_close_stops, in_valid && in_ready && set_end, !in_ready,
                    "intake open after end of set")

endmodule

bind hull_vertex_ccw_ordering_unit hv_checker #(.COORD_BITS(COORD_BITS)) u_hv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .set_end   (in_ch.set_end),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_x     (out_ch.out_x),
    .out_y     (out_ch.out_y),
    .out_end   (out_ch.out_end)
);

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Hull vertex ordering unit testbench
// Loads point sets through the input channel and compares every vertex the
// unit emits against a local model of the counterclockwise ordering: the
// right point, the upper half, the left point, then the lower half. A short
// table of directed sets runs first, then an overflow set, and then random
// convex and noisy sets, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXP = 64;
    localparam int CB   = 16;
    localparam longint CYCLE_LIMIT = 64'd3000000;

    typedef struct {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic                 fin;
        logic                 xend;
        logic                 xovf;
        logic                 has_exp;
    } stim_row_t;

    typedef struct {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic                 fin;
        logic                 ovf;
    } vertex_t;

    logic clk;
    logic rst_n;
    hv_point_if  #(.COORD_BITS(CB)) in_ch();
    hv_vertex_if #(.COORD_BITS(CB)) out_ch();

    hull_vertex_ccw_ordering_unit #(.MAX_POINTS(MAXP), .COORD_BITS(CB)) dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

    // Model state
    logic signed [CB-1:0] held_x [MAXP];
    logic signed [CB-1:0] held_y [MAXP];
    int      held_cnt;
    bit      held_drop;
    vertex_t pending_vertices[$];
    int      err_cnt;
    int      vtx_seen;
    int      sets_done;
    longint  cyc;
    stim_row_t table_rows[$];

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Ordering key for the two halves
    function automatic bit ahead(int a, int b, bit up);
        if (held_x[a] == held_x[b])
            return up ? (held_y[a] < held_y[b]) : (held_y[a] > held_y[b]);
        return up ? (held_x[a] > held_x[b]) : (held_x[a] < held_x[b]);
    endfunction

    // Store a point and, on the last one, queue the ordered vertices
    task automatic hull_order_point(logic signed [CB-1:0] px, logic signed [CB-1:0] py,
                                    logic fin);
        int up_l[$];
        int lo_l[$];
        int seq[$];
        int r, l, t, j;
        longint signed ex, ey, dx, dy;
        vertex_t v;
        if (held_cnt < MAXP)
        begin
            held_x[held_cnt] = px;
            held_y[held_cnt] = py;
            held_cnt++;
        end
        else
            held_drop = 1'b1;
        if (!fin)
            return;
        r = 0;
        l = 0;
        for (int i = 1; i < held_cnt; i++)
        begin
            if (held_x[i] > held_x[r] || (held_x[i] == held_x[r] && held_y[i] < held_y[r]))
                r = i;
            if (held_x[i] < held_x[l] || (held_x[i] == held_x[l] && held_y[i] > held_y[l]))
                l = i;
        end
        if (held_cnt > 1 && l == r)
            l = (r == held_cnt - 1) ? 0 : held_cnt - 1;
        ex = longint'(held_x[l]) - longint'(held_x[r]);
        ey = longint'(held_y[l]) - longint'(held_y[r]);
        for (int i = 0; i < held_cnt; i++)
        begin
            if (i == r || i == l)
                continue;
            dx = longint'(held_x[i]) - longint'(held_x[r]);
            dy = longint'(held_y[i]) - longint'(held_y[r]);
            if (ex * dy < ey * dx)
                up_l = {up_l, i};
            else
                lo_l = {lo_l, i};
        end
        // Insertion sort each half, stable like the hardware selection
        for (int i = 1; i < up_l.size(); i++)
        begin
            t = up_l[i];
            j = i;
            while (j > 0 && ahead(t, up_l[j-1], 1'b1))
            begin
                up_l[j] = up_l[j-1];
                j--;
            end
            up_l[j] = t;
        end
        for (int i = 1; i < lo_l.size(); i++)
        begin
            t = lo_l[i];
            j = i;
            while (j > 0 && ahead(t, lo_l[j-1], 1'b0))
            begin
                lo_l[j] = lo_l[j-1];
                j--;
            end
            lo_l[j] = t;
        end
        seq = {seq, r};
        foreach (up_l[i]) seq = {seq, up_l[i]};
        if (held_cnt > 1)
            seq = {seq, l};
        foreach (lo_l[i]) seq = {seq, lo_l[i]};
        foreach (seq[i])
        begin
            v.x   = held_x[seq[i]];
            v.y   = held_y[seq[i]];
            v.fin = (i == seq.size() - 1);
            v.ovf = held_drop;
            pending_vertices = {pending_vertices, v};
        end
        held_cnt  = 0;
        held_drop = 1'b0;
    endtask

    // Random gap, mostly short
    function automatic int gap_len();
        int c;
        c = $urandom_range(0, 99);
        if (c < 40)
            return 0;
        if (c < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Send one item and run it through the model
    task automatic push_point(logic signed [CB-1:0] px, logic signed [CB-1:0] py,
                              logic fin);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.point_x <= px;
        in_ch.point_y <= py;
        in_ch.set_end <= fin;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        hull_order_point(px, py, fin);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge clk);
    endtask

    // Random convex polygon around a center, or a set of uniformly random points
    task automatic random_set(int n, bit noisy);
        int cx, cy, rad;
        real ang;
        logic signed [CB-1:0] px, py;
        cx  = $urandom_range(0, 40000) - 20000;
        cy  = $urandom_range(0, 40000) - 20000;
        rad = $urandom_range(1, 12000);
        for (int i = 0; i < n; i++)
        begin
            if (noisy)
            begin
                px = CB'($urandom);
                py = CB'($urandom);
            end
            else
            begin
                ang = 6.2831853 * i / n;
                px = CB'(cx + $rtoi(rad * $cos(ang)));
                py = CB'(cy + $rtoi(rad * $sin(ang)));
            end
            push_point(px, py, i == n - 1);
        end
    endtask

    // Output side: random stalls and checking
    initial
    begin
        vertex_t e;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                vtx_seen++;
                if (pending_vertices.size() == 0)
                begin
                    $error("vertex with nothing expected: x=%0d y=%0d", out_ch.out_x,
                           out_ch.out_y);
                    err_cnt++;
                end
                else
                begin
                    e = pending_vertices.pop_front();
                    if (out_ch.out_x !== e.x)
                    begin
                        $error("out_x expected %0d actual %0d", e.x, out_ch.out_x);
                        err_cnt++;
                    end
                    if (out_ch.out_y !== e.y)
                    begin
                        $error("out_y expected %0d actual %0d", e.y, out_ch.out_y);
                        err_cnt++;
                    end
                    if (out_ch.out_end !== e.fin)
                    begin
                        $error("out_end expected %0d actual %0d", e.fin, out_ch.out_end);
                        err_cnt++;
                    end
                    if (out_ch.overflowed !== e.ovf)
                    begin
                        $error("overflowed expected %0d actual %0d", e.ovf,
                               out_ch.overflowed);
                        err_cnt++;
                    end
                    if (e.fin)
                        sets_done++;
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) < 20) ? 1'b0 : 1'b1;
        end
    end

    // Directed table row helper
    function automatic stim_row_t row(int px, int py, bit fin, bit he, bit xe, bit xo);
        stim_row_t s;
        s.x = CB'(px); s.y = CB'(py); s.fin = fin; s.has_exp = he; s.xend = xe;
        s.xovf = xo;
        return s;
    endfunction

    // Stimulus
    initial
    begin
        int sent;
        vertex_t h;
        cyc = 0; err_cnt = 0; vtx_seen = 0; sets_done = 0;
        held_cnt = 0; held_drop = 1'b0;
        rst_n = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.point_x <= '0;
        in_ch.point_y <= '0;
        in_ch.set_end <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single point at the extremes, two points, all identical, a square
        table_rows = {table_rows, row(-32768, 32767, 1, 1, 1, 0)};
        table_rows = {table_rows, row(32767, -32768, 0, 0, 0, 0)};
        table_rows = {table_rows, row(-32768, 32767, 1, 0, 0, 0)};
        table_rows = {table_rows, row(5, 5, 0, 0, 0, 0)};
        table_rows = {table_rows, row(5, 5, 0, 0, 0, 0)};
        table_rows = {table_rows, row(5, 5, 1, 0, 0, 0)};
        table_rows = {table_rows, row(0, 0, 0, 0, 0, 0)};
        table_rows = {table_rows, row(100, 0, 0, 0, 0, 0)};
        table_rows = {table_rows, row(100, 100, 0, 0, 0, 0)};
        table_rows = {table_rows, row(0, 100, 0, 0, 0, 0)};
        table_rows = {table_rows, row(50, 50, 0, 0, 0, 0)};
        table_rows = {table_rows, row(-1, -1, 0, 0, 0, 0)};
        table_rows = {table_rows, row(32767, 32767, 0, 0, 0, 0)};
        table_rows = {table_rows, row(-32768, -32768, 1, 0, 0, 0)};
        table_rows = {table_rows, row(-3, 7, 0, 0, 0, 0)};
        table_rows = {table_rows, row(9, 7, 1, 0, 0, 0)};
        foreach (table_rows[i])
        begin
            push_point(table_rows[i].x, table_rows[i].y, table_rows[i].fin);
            if (table_rows[i].has_exp)
            begin
                h = pending_vertices[pending_vertices.size() - 1];
                if (h.fin !== table_rows[i].xend || h.ovf !== table_rows[i].xovf)
                begin
                    $error("directed row %0d: out_end expected %0d overflowed %0d",
                           i, table_rows[i].xend, table_rows[i].xovf);
                    err_cnt++;
                end
            end
        end
        wait_drained();

        // Overflow: a full store then two dropped points
        for (int i = 0; i < MAXP + 2; i++)
            push_point(CB'($urandom), CB'($urandom), i == MAXP + 1);
        wait_drained();

        // Random sets, mostly small
        sent = 0;
        while (sent < 210)
        begin
            int n;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, MAXP)
                                             : $urandom_range(1, 8);
            random_set(n, $urandom_range(0, 3) == 0);
            sent += n;
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (200) @(posedge clk);
        $display("Ran %0d sets, %0d vertices checked, including extreme, degenerate,",
                 sets_done, vtx_seen);
        $display("overflow and random convex or noisy sets under random stalls.");
        if (err_cnt == 0 && pending_vertices.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
